// ----- rtl/lsf_pkg.sv -----
// Package for the load-scaled fee block: widths, status codes, divider commands.
// Depends on nothing; the divider, multiplier and fee modules import it.
`default_nettype none
package lsf_pkg;
	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;
	localparam int unsigned PrivMult = 4;
	localparam logic [31:0] LoadBaseRst = 32'd256;
	localparam int unsigned AddrW = 1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_ZERO_DEN = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic [WordW-1:0] num;
		logic [WordW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [WordW-1:0] quo;
		logic [WordW-1:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/lsf_if.sv -----
// Valid/ready channel interfaces for the load-scaled fee block.
// Depends on nothing.
`default_nettype none
interface lsf_in_if;
	logic valid;
	logic ready;
	logic [63:0] fee;
	logic [63:0] base_fee;
	logic [31:0] fee_units;
	logic [31:0] local_factor;
	logic [31:0] remote_factor;
	logic privileged;
	modport source(output valid, fee, base_fee, fee_units, local_factor, remote_factor,
		privileged, input ready);
	modport sink(input valid, fee, base_fee, fee_units, local_factor, remote_factor,
		privileged, output ready);
endinterface

interface lsf_out_if;
	logic valid;
	logic ready;
	logic [63:0] scaled_fee;
	logic [1:0] status;
	modport source(output valid, scaled_fee, status, input ready);
	modport sink(input valid, scaled_fee, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/lsf_div.sv -----
// Shared radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on lsf_pkg.
`default_nettype none
module lsf_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire lsf_pkg::div_req_t req,
	output lsf_pkg::div_rsp_t rsp
);
	import lsf_pkg::*;
	logic busy_q;
	logic done_q;
	logic [6:0] cnt_q;
	logic [WordW-1:0] q_q, r_q, d_q;
	logic [WordW:0] trial;

	assign trial = {r_q, q_q[WordW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(WordW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			r_q <= '0;
			d_q <= req.den;
		end else if (busy_q) begin
			if (!trial[WordW]) begin
				r_q <= trial[WordW-1:0];
				q_q <= {q_q[WordW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[WordW-2:0], q_q[WordW-1]};
				q_q <= {q_q[WordW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = q_q;
	assign rsp.rem = r_q;
endmodule
`default_nettype wire

// ----- rtl/lsf_mul.sv -----
// 64 by 64 multiplier with overflow detect, built from 32x32 partial products,
// one partial product per cycle. Depends on lsf_pkg.
`default_nettype none
module lsf_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [lsf_pkg::WordW-1:0] a,
	input wire logic [lsf_pkg::WordW-1:0] b,
	output logic done,
	output logic [lsf_pkg::WordW-1:0] prod,
	output logic ovf
);
	import lsf_pkg::*;
	logic [2:0] step_q;
	logic [HalfW-1:0] x, y;
	logic [WordW-1:0] pp;
	logic [WordW-1:0] a_q, b_q, lo_q;
	logic [WordW:0] mid_q;
	logic hi_q;

	always_comb begin
		case (step_q)
			3'd1: begin x = a_q[HalfW-1:0]; y = b_q[HalfW-1:0]; end
			3'd2: begin x = a_q[WordW-1:HalfW]; y = b_q[HalfW-1:0]; end
			3'd3: begin x = a_q[HalfW-1:0]; y = b_q[WordW-1:HalfW]; end
			default: begin x = '0; y = '0; end
		endcase
	end
	assign pp = 64'(x) * 64'(y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) step_q <= 3'd1;
			else if (step_q == 3'd4) begin
				step_q <= '0;
				done <= 1'b1;
			end else if (step_q != 3'd0) step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			hi_q <= (a[WordW-1:HalfW] != '0) && (b[WordW-1:HalfW] != '0);
			mid_q <= '0;
		end else begin
			case (step_q)
				3'd1: begin
					lo_q <= pp;
					mid_q <= 65'(pp[WordW-1:HalfW]);
				end
				3'd2, 3'd3: mid_q <= mid_q + 65'(pp);
				3'd4: begin
					prod <= {mid_q[HalfW-1:0], lo_q[HalfW-1:0]};
					ovf <= hi_q || (mid_q[WordW:HalfW] != '0);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/load_scaled_fee_muldiv.sv -----
// Load-scaled fee: fee*base*factor/(units*load_base) with gcd reduction.
// Latency: data dependent. A zero fee goes straight to the output; a zero denominator
// ends after the denominator product. Otherwise three gcd reductions (Euclid steps
// plus two divides each), three or four products and a final divide.
// Throughput: one item at a time; in.ready only while idle.
// Reset: asynchronous, active low; load_base returns to 256, sequencer to idle.
`default_nettype none
module load_scaled_fee_muldiv (
	input wire logic clk,
	input wire logic arst_n,
	lsf_in_if.sink in_ch,
	lsf_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lsf_pkg::AddrW+1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lsf_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_DEN = 12'b000000000010,
		S_DENW = 12'b000000000100,
		S_GCD = 12'b000000001000,
		S_GCDW = 12'b000000010000,
		S_RA = 12'b000000100000,
		S_RAW = 12'b000001000000,
		S_RD = 12'b000010000000,
		S_RDW = 12'b000100000000,
		S_MUL = 12'b001000000000,
		S_MULW = 12'b010000000000,
		S_OUT = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [31:0] load_base_q;
	logic [WordW-1:0] fee_q, base_q, fac_q, den_q, x_q, y_q, tmp_q;
	logic [1:0] term_q;
	logic [1:0] phase_q;
	logic [WordW-1:0] res_q;
	status_t st_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic mstart, mdone, movf;
	logic [WordW-1:0] ma, mb, mprod;

	lsf_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));
	lsf_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .done(mdone),
		.prod(mprod), .ovf(movf));

	assign pready = 1'b1;
	assign prdata = (paddr[AddrW+1:2] == '0) ? load_base_q : 32'd0;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.scaled_fee = res_q;
	assign out_ch.status = st_q;

	logic [WordW-1:0] term;
	always_comb begin
		case (term_q)
			2'd0: term = fee_q;
			2'd1: term = base_q;
			default: term = fac_q;
		endcase
	end

	logic [33:0] rem4;
	logic [31:0] fsel;
	assign rem4 = 34'(in_ch.remote_factor) * 34'(PrivMult);
	assign fsel = (in_ch.privileged && in_ch.local_factor > in_ch.remote_factor
		&& 34'(in_ch.local_factor) < rem4) ? in_ch.remote_factor : in_ch.local_factor;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = x_q;
		dreq.den = y_q;
		mstart = 1'b0;
		ma = x_q;
		mb = y_q;
		case (state_q)
			S_GCD: dreq.start = (y_q != '0);
			S_RA: dreq.start = 1'b1;
			S_RD: dreq.start = 1'b1;
			S_MUL: begin
				mstart = 1'b1;
				case (phase_q)
					2'd1: begin
						ma = (fee_q < base_q) ? fee_q : base_q;
						mb = fac_q;
					end
					2'd2: begin
						ma = fee_q;
						mb = base_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= LoadBaseRst;
		end else if (psel && penable && pwrite && paddr[AddrW+1:2] == '0) begin
			load_base_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					fee_q <= in_ch.fee;
					base_q <= in_ch.base_fee;
					fac_q <= 64'(fsel);
					x_q <= 64'(in_ch.fee_units);
					y_q <= 64'(load_base_q);
					st_q <= ST_OK;
					res_q <= '0;
					term_q <= 2'd0;
					if (in_ch.fee == '0) state_q <= S_OUT;
					else state_q <= S_DEN;
				end
				S_DEN: begin
					phase_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_GCD: begin
					if (y_q == '0) begin
						tmp_q <= x_q;
						x_q <= term;
						y_q <= x_q;
						state_q <= S_RA;
					end else state_q <= S_GCDW;
				end
				S_GCDW: if (drsp.done) begin
					x_q <= y_q;
					y_q <= drsp.rem;
					state_q <= S_GCD;
				end
				S_RA: state_q <= S_RAW;
				S_RAW: if (drsp.done) begin
					case (term_q)
						2'd0: fee_q <= drsp.quo;
						2'd1: base_q <= drsp.quo;
						2'd2: fac_q <= drsp.quo;
						default: ;
					endcase
					if (term_q != 2'd3) begin
						x_q <= den_q;
						y_q <= tmp_q;
						state_q <= S_RD;
					end else if (phase_q == 2'd3) begin
						x_q <= drsp.quo;
						y_q <= base_q;
						state_q <= S_MUL;
					end else begin
						res_q <= drsp.quo;
						state_q <= S_OUT;
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: if (drsp.done) begin
					den_q <= drsp.quo;
					if (term_q == 2'd2) begin
						state_q <= S_MUL;
						phase_q <= 2'd1;
					end else begin
						term_q <= term_q + 2'd1;
						x_q <= (term_q == 2'd0) ? base_q : fac_q;
						y_q <= drsp.quo;
						state_q <= S_GCD;
					end
				end
				S_MUL: begin
					if ((phase_q == 2'd1 || phase_q == 2'd2) && fee_q < base_q) begin
						fee_q <= base_q;
						base_q <= fee_q;
					end
					state_q <= S_MULW;
				end
				S_MULW: if (mdone) begin
					case (phase_q)
						2'd0: begin
							if (mprod == '0) begin
								st_q <= ST_ZERO_DEN;
								state_q <= S_OUT;
							end else begin
								den_q <= mprod;
								x_q <= fee_q;
								y_q <= mprod;
								state_q <= S_GCD;
							end
						end
						2'd1: begin
							if (base_q == '0 || fac_q == '0) state_q <= S_OUT;
							else if (movf) begin
								st_q <= ST_OVERFLOW;
								state_q <= S_OUT;
							end else begin
								base_q <= mprod;
								phase_q <= 2'd2;
								state_q <= S_MUL;
							end
						end
						2'd2: begin
							if (movf) begin
								x_q <= fee_q;
								y_q <= den_q;
								phase_q <= 2'd3;
								state_q <= S_RA;
								term_q <= 2'd3;
							end else begin
								x_q <= mprod;
								y_q <= den_q;
								phase_q <= 2'd0;
								term_q <= 2'd3;
								state_q <= S_RA;
								tmp_q <= '0;
							end
						end
						default: begin
							if (movf) begin
								st_q <= ST_OVERFLOW;
								res_q <= '0;
							end else res_q <= mprod;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
